// File: hdl/ppmd_pkg.sv
package ppmd_pkg;

  // default geometry
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 1'd1;

endpackage

// File: hdl/ppmd_vert_if.sv
interface ppmd_vert_if
  import ppmd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         first_vertex;
  logic                         last_vertex;

  modport source (output valid, vertex_x, vertex_y, first_vertex, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, first_vertex, last_vertex,
                  output ready);
endinterface

// File: hdl/ppmd_res_if.sv
interface ppmd_res_if
  import ppmd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic                         valid;
  logic                         ready;
  logic        [DIST_W-1:0]     min_dist_sq;
  logic signed [COORD_BITS-1:0] nearest_x;
  logic signed [COORD_BITS-1:0] nearest_y;
  logic                         no_segment;

  modport source (output valid, min_dist_sq, nearest_x, nearest_y, no_segment,
                  input ready);
  modport sink   (input valid, min_dist_sq, nearest_x, nearest_y, no_segment,
                  output ready);
endinterface

// File: hdl/point_polyline_min_distance.sv
// Smallest squared distance from a query point (cfg registers 0 and 1) to a
// polyline whose vertices arrive one word at a time. Each vertex after the
// first closes a segment; its nearest point is found by projection with a
// Q0.FRAC_BITS parameter and rounded, and the closest segment is kept (the
// earlier one on a tie). A word flagged last_vertex yields one result word,
// with no_segment set if no segment was formed. One shared signed multiplier
// and a radix-2 restoring divider under a small sequencer do all the work,
// so one vertex is accepted at a time. A vertex that closes no segment
// needs no arithmetic; a segment passes the multiply, decide and distance
// steps, and one whose nearest point lies inside it also the divide and
// project steps, the divider giving one quotient bit per cycle. A last
// vertex then passes the emit step, which waits while an earlier result
// still sits in the output register; the register holds the result until
// taken while the next vertex is already being processed.
module point_polyline_min_distance
  import ppmd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  ppmd_vert_if.sink             in_vert,
  ppmd_res_if.source            out_res
);

  localparam int DW     = COORD_BITS + 1;                 // coordinate differences
  localparam int DIST_W = 2 * COORD_BITS + 2;             // lengths and distances
  localparam int OPW    = (DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1;
  localparam int PW     = 2 * OPW;                        // product
  localparam int ACC_W  = PW + 2;                         // accumulator
  localparam int CNT_W  = $clog2(FRAC_BITS);
  localparam logic [DIST_W-1:0] NO_BEST = '1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (FRAC_BITS - 1));

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DECIDE, S_DIV, S_PROJ, S_DIST, S_EMIT
  } state_t;

  state_t                  state_r;
  logic [2:0]              step_r;
  logic [CNT_W-1:0]        cnt_r;

  logic signed [COORD_BITS-1:0] query_x_r, query_y_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic                         have_prev_r;
  logic        [DIST_W-1:0]     best_r;
  logic signed [COORD_BITS-1:0] best_x_r, best_y_r;
  logic                         last_r;

  // segment working registers
  logic signed [COORD_BITS-1:0] sx_r, sy_r;
  logic signed [DW-1:0]         a_r, b_r, c_r, d_r;
  logic signed [DW-1:0]         off_x_r, off_y_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic        [DIST_W-1:0]     len_r;
  logic        [DIST_W-1:0]     rem_r;
  logic        [FRAC_BITS-1:0]  quo_r;

  // result register
  logic                         out_valid_r;
  logic        [DIST_W-1:0]     out_dist_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                         out_nos_r;

  logic signed [OPW-1:0]   op_a, op_b;
  logic signed [PW-1:0]    prod_nxt;
  logic signed [DW-1:0]    dx_w, dy_w;
  logic signed [ACC_W-1:0] rnd_sum, rnd_sh;
  logic        [DIST_W:0]  rem2;
  logic        [DIST_W:0]  rem_diff;
  logic                    rem_ge;
  logic signed [DW-1:0]    mx_w, my_w;
  logic signed [DW-1:0]    qx_w, qy_w, px_w, py_w, vx_w, vy_w;
  logic                    emit_ok;

  // handshake
  assign in_vert.ready       = (state_r == S_IDLE);
  assign out_res.valid       = out_valid_r;
  assign out_res.min_dist_sq = out_dist_r;
  assign out_res.nearest_x   = out_x_r;
  assign out_res.nearest_y   = out_y_r;
  assign out_res.no_segment  = out_nos_r;
  assign emit_ok             = !out_valid_r || out_res.ready;

  // widened coordinates
  assign qx_w = DW'(query_x_r);
  assign qy_w = DW'(query_y_r);
  assign px_w = DW'(prev_x_r);
  assign py_w = DW'(prev_y_r);
  assign vx_w = DW'(in_vert.vertex_x);
  assign vy_w = DW'(in_vert.vertex_y);

  // offset from the candidate nearest point to the query point
  assign dx_w = a_r - off_x_r;
  assign dy_w = b_r - off_y_r;

  // shared multiplier operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_MUL: begin
        unique case (step_r)
          3'd0:    begin op_a = OPW'(c_r); op_b = OPW'(c_r); end
          3'd1:    begin op_a = OPW'(d_r); op_b = OPW'(d_r); end
          3'd2:    begin op_a = OPW'(a_r); op_b = OPW'(c_r); end
          3'd3:    begin op_a = OPW'(b_r); op_b = OPW'(d_r); end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      S_PROJ: begin
        unique case (step_r)
          3'd0:    begin op_a = OPW'(quo_r); op_b = OPW'(c_r); end
          3'd1:    begin op_a = OPW'(quo_r); op_b = OPW'(d_r); end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      S_DIST: begin
        unique case (step_r)
          3'd0:    begin op_a = OPW'(dx_w); op_b = OPW'(dx_w); end
          3'd1:    begin op_a = OPW'(dy_w); op_b = OPW'(dy_w); end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  // round param * delta to nearest, halves upwards
  assign rnd_sum = ACC_W'(prod_r) + HALF;
  assign rnd_sh  = rnd_sum >>> FRAC_BITS;

  // divider step
  assign rem2     = {rem_r, 1'b0};
  assign rem_diff = rem2 - {1'b0, len_r};
  assign rem_ge   = (rem2 >= {1'b0, len_r});

  // candidate nearest point
  assign mx_w = DW'(sx_r) + off_x_r;
  assign my_w = DW'(sy_r) + off_y_r;

  // sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      query_x_r   <= '0;
      query_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      best_r      <= NO_BEST;
      best_x_r    <= '0;
      best_y_r    <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prod_r <= prod_nxt;

      // word taken; the emit step reloads it itself
      if (out_res.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_QUERY_X: query_x_r <= cfg_wdata;
          REG_QUERY_Y: query_y_r <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_vert.valid) begin
            sx_r        <= prev_x_r;
            sy_r        <= prev_y_r;
            a_r         <= qx_w - px_w;
            b_r         <= qy_w - py_w;
            c_r         <= vx_w - px_w;
            d_r         <= vy_w - py_w;
            last_r      <= in_vert.last_vertex;
            prev_x_r    <= in_vert.vertex_x;
            prev_y_r    <= in_vert.vertex_y;
            have_prev_r <= 1'b1;
            step_r      <= '0;
            if (in_vert.first_vertex) begin
              best_r   <= NO_BEST;
              best_x_r <= '0;
              best_y_r <= '0;
            end
            priority if (have_prev_r && !in_vert.first_vertex) begin
              state_r <= S_MUL;
            end else if (in_vert.last_vertex) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        // len = c*c + d*d, dot = a*c + b*d
        S_MUL: begin
          step_r <= step_r + 3'd1;
          unique case (step_r)
            3'd1:    acc_r <= ACC_W'(prod_r);
            3'd2:    acc_r <= acc_r + ACC_W'(prod_r);
            3'd3:    begin
              len_r <= acc_r[DIST_W-1:0];
              acc_r <= ACC_W'(prod_r);
            end
            3'd4:    begin
              acc_r   <= acc_r + ACC_W'(prod_r);
              state_r <= S_DECIDE;
            end
            default: ;
          endcase
        end

        // clamp to an end point or start the division
        S_DECIDE: begin
          step_r <= '0;
          priority if (len_r == '0 || acc_r <= 0) begin
            off_x_r <= '0;
            off_y_r <= '0;
            state_r <= S_DIST;
          end else if (acc_r >= $signed(ACC_W'(len_r))) begin
            off_x_r <= c_r;
            off_y_r <= d_r;
            state_r <= S_DIST;
          end else begin
            rem_r   <= acc_r[DIST_W-1:0];
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end

        // param = floor(dot * 2^FRAC_BITS / len), one bit per cycle
        S_DIV: begin
          if (rem_ge) begin
            rem_r <= rem_diff[DIST_W-1:0];
          end else begin
            rem_r <= rem2[DIST_W-1:0];
          end
          quo_r <= {quo_r[FRAC_BITS-2:0], rem_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
            step_r  <= '0;
            state_r <= S_PROJ;
          end
        end

        // rounded offsets along the segment
        S_PROJ: begin
          unique case (step_r)
            3'd1:    begin
              off_x_r <= rnd_sh[DW-1:0];
              step_r  <= 3'd2;
            end
            3'd2:    begin
              off_y_r <= rnd_sh[DW-1:0];
              step_r  <= '0;
              state_r <= S_DIST;
            end
            default: step_r <= 3'd1;
          endcase
        end

        // squared distance and running minimum
        S_DIST: begin
          step_r <= step_r + 3'd1;
          unique case (step_r)
            3'd1:    acc_r <= ACC_W'(prod_r);
            3'd2:    acc_r <= acc_r + ACC_W'(prod_r);
            3'd3:    begin
              if (acc_r[DIST_W-1:0] < best_r) begin
                best_r   <= acc_r[DIST_W-1:0];
                best_x_r <= mx_w[COORD_BITS-1:0];
                best_y_r <= my_w[COORD_BITS-1:0];
              end
              state_r <= last_r ? S_EMIT : S_IDLE;
            end
            default: ;
          endcase
        end

        // hand the result over and clear the search
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            if (best_r == NO_BEST) begin
              out_dist_r <= '0;
              out_x_r    <= '0;
              out_y_r    <= '0;
              out_nos_r  <= 1'b1;
            end else begin
              out_dist_r <= best_r;
              out_x_r    <= best_x_r;
              out_y_r    <= best_y_r;
              out_nos_r  <= 1'b0;
            end
            have_prev_r <= 1'b0;
            best_r      <= NO_BEST;
            best_x_r    <= '0;
            best_y_r    <= '0;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the divider only runs on a non-degenerate segment
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (len_r != '0))
    else $error("division started on a zero-length segment");

  // restoring remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < len_r))
    else $error("divider remainder out of range");

  // a found minimum implies an open polyline
  a_best_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (best_r != NO_BEST) |-> have_prev_r)
    else $error("minimum held without a polyline in progress");

  // an empty result carries zero fields
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nos_r) |-> (out_dist_r == '0 && out_x_r == '0 && out_y_r == '0))
    else $error("empty result with non-zero fields");

  // a result word is only loaded from the emit state
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_EMIT))
    else $error("result word appeared outside the emit step");

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppmd_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int DW = 2 * CB + 2;
  localparam logic [DW-1:0] DIST_NONE = '1;
  // extra wait after every expected word has come out
  localparam int SETTLE_CYCLES = 50;
  localparam int STALL_LIMIT = 2000;

  // coordinate styles for random polylines
  localparam int STYLE_WIDE = 0;
  localparam int STYLE_NEAR = 1;
  localparam int STYLE_EDGE = 2;

  typedef struct packed {
    logic [DW-1:0]        dsq;
    logic signed [CB-1:0] nx;
    logic signed [CB-1:0] ny;
    logic                 empty;
  } nearest_rec_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CB-1:0]        cfg_wdata;

  ppmd_vert_if #(.COORD_BITS(CB)) vert ();
  ppmd_res_if  #(.COORD_BITS(CB)) res ();

  point_polyline_min_distance #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_vert  (vert),
    .out_res  (res)
  );

  // predictor state
  logic signed [CB-1:0] qry_x, qry_y;
  logic signed [CB-1:0] held_x, held_y;
  logic                 held_valid;
  logic [DW-1:0]        closest_dist;
  logic signed [CB-1:0] closest_x, closest_y;
  nearest_rec_t         nearest_due[$];

  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 80;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void restart_polyline();
    held_valid   = 1'b0;
    closest_dist = DIST_NONE;
    closest_x    = '0;
    closest_y    = '0;
  endfunction

  // nearest point of one segment by projection, keep it if strictly closer
  function automatic void measure_segment(longint sx, longint sy, longint ex, longint ey);
    longint qx, qy, ax, ay, cx, cy, seg_len, dot, frac, half, mx, my, dx, dy, dsq;
    qx = longint'(qry_x);
    qy = longint'(qry_y);
    ax = qx - sx;
    ay = qy - sy;
    cx = ex - sx;
    cy = ey - sy;
    seg_len = cx * cx + cy * cy;
    dot = ax * cx + ay * cy;
    if (seg_len == 0 || dot <= 0) begin
      mx = sx;
      my = sy;
    end else if (dot >= seg_len) begin
      mx = ex;
      my = ey;
    end else begin
      frac = (dot <<< FB) / seg_len;
      half = longint'(1) <<< (FB - 1);
      // arithmetic shift floors, so halves round towards plus infinity
      mx = sx + ((frac * cx + half) >>> FB);
      my = sy + ((frac * cy + half) >>> FB);
    end
    dx = qx - mx;
    dy = qy - my;
    dsq = dx * dx + dy * dy;
    if (dsq < closest_dist) begin
      closest_dist = dsq[DW-1:0];
      closest_x    = mx[CB-1:0];
      closest_y    = my[CB-1:0];
    end
  endfunction

  function automatic void track_vertex(logic signed [CB-1:0] vx, logic signed [CB-1:0] vy,
                                       logic first, logic last);
    nearest_rec_t rec;
    if (first)
      restart_polyline();
    if (held_valid)
      measure_segment(longint'(held_x), longint'(held_y), longint'(vx), longint'(vy));
    held_x     = vx;
    held_y     = vy;
    held_valid = 1'b1;
    if (last) begin
      if (closest_dist == DIST_NONE) begin
        rec.dsq   = '0;
        rec.nx    = '0;
        rec.ny    = '0;
        rec.empty = 1'b1;
      end else begin
        rec.dsq   = closest_dist;
        rec.nx    = closest_x;
        rec.ny    = closest_y;
        rec.empty = 1'b0;
      end
      nearest_due.push_back(rec);
      restart_polyline();
    end
  endfunction

  // one vertex word; returns at the falling edge after acceptance, valid left high
  task automatic send_vertex(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                             input logic first, input logic last);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) begin
        vert.valid <= 1'b0;
        lowered = 1'b1;
      end
      @(negedge clk);
    end
    vert.vertex_x     <= x;
    vert.vertex_y     <= y;
    vert.first_vertex <= first;
    vert.last_vertex  <= last;
    vert.valid        <= 1'b1;
    @(posedge clk);
    while (!vert.ready)
      @(posedge clk);
    track_vertex(x, y, first, last);
    @(negedge clk);
  endtask

  // stop sending and let every expected word come out
  task automatic drain_block();
    vert.valid <= 1'b0;
    while (nearest_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only called while the block is idle
  task automatic set_query(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y);
    cfg_we    <= 1'b1;
    cfg_index <= REG_QUERY_X;
    cfg_wdata <= x;
    @(negedge clk);
    cfg_index <= REG_QUERY_Y;
    cfg_wdata <= y;
    @(negedge clk);
    cfg_we <= 1'b0;
    qry_x = x;
    qry_y = y;
  endtask

  function automatic logic signed [CB-1:0] pick_coord(int style, logic signed [CB-1:0] centre,
                                                      int spread);
    int off;
    case (style)
      STYLE_NEAR: begin
        off = int'($urandom_range(2 * spread)) - spread;
        return CB'(centre + off);
      end
      STYLE_EDGE: begin
        case ($urandom_range(4))
          0:       return CB'(-(2 ** (CB - 1)));
          1:       return CB'(2 ** (CB - 1) - 1);
          2:       return '0;
          3:       return CB'(-1);
          default: return CB'(1);
        endcase
      end
      default: return CB'($urandom);
    endcase
  endfunction

  // one-vertex polylines, with and without the first flag
  task automatic test_lone_vertex();
    send_vertex(5, 5, 1'b0, 1'b1);
    send_vertex(7, -3, 1'b1, 1'b1);
    drain_block();
  endtask

  // coordinate extremes, zero-length segment, largest distance
  task automatic test_extreme_coords();
    set_query(-32768, -32768);
    send_vertex(32767, 32767, 1'b1, 1'b0);
    send_vertex(32767, 32767, 1'b0, 1'b1);
    drain_block();
    set_query(32767, -32768);
    send_vertex(-32768, 32767, 1'b1, 1'b0);
    send_vertex(32767, 32767, 1'b0, 1'b0);
    send_vertex(-32768, -32768, 1'b0, 1'b1);
    drain_block();
  endtask

  // interior point, clamp to start, clamp to end, tie, rounding both ways
  task automatic test_projection_cases();
    set_query(0, 0);
    send_vertex(-100, 50, 1'b1, 1'b0);
    send_vertex(100, 50, 1'b0, 1'b0);
    send_vertex(300, 70, 1'b0, 1'b0);
    send_vertex(100, 50, 1'b0, 1'b0);
    send_vertex(50, 0, 1'b0, 1'b1);
    send_vertex(-1, 1, 1'b1, 1'b0);
    send_vertex(2, 1, 1'b0, 1'b1);
    send_vertex(2, 1, 1'b1, 1'b0);
    send_vertex(-1, 1, 1'b0, 1'b0);
    send_vertex(-40, 3, 1'b0, 1'b1);
    drain_block();
  endtask

  // first flag mid-polyline restarts; missing first after a result starts afresh
  task automatic test_restart_flags();
    set_query(10, 10);
    send_vertex(0, 0, 1'b1, 1'b0);
    send_vertex(20, 0, 1'b0, 1'b0);
    send_vertex(1000, 1000, 1'b1, 1'b0);
    send_vertex(1000, 2000, 1'b0, 1'b1);
    send_vertex(0, 20, 1'b0, 1'b0);
    send_vertex(20, 20, 1'b0, 1'b1);
    drain_block();
  endtask

  // query moves between segments of one polyline
  task automatic test_query_change();
    set_query(0, 0);
    send_vertex(-50, 10, 1'b1, 1'b0);
    send_vertex(50, 10, 1'b0, 1'b0);
    drain_block();
    set_query(0, 100);
    send_vertex(1, 100, 1'b0, 1'b0);
    send_vertex(-20, 300, 1'b0, 1'b1);
    drain_block();
  endtask

  // random polylines: mostly well formed, some missing or stray flags
  task automatic run_random(input int n_items, input int sender_pct, input int receiver_pct);
    int sent, n_vert, style, spread, sel, i;
    logic signed [CB-1:0] x, y;
    logic first, last;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        drain_block();
        style = $urandom_range(2);
        x = pick_coord(style, '0, 256);
        y = pick_coord(style, '0, 256);
        set_query(x, y);
      end
      sel = $urandom_range(99);
      n_vert = (sel < 5) ? 1 : (sel < 85) ? $urandom_range(6, 2) : $urandom_range(20, 7);
      sel = $urandom_range(99);
      style = (sel < 40) ? STYLE_WIDE : (sel < 85) ? STYLE_NEAR : STYLE_EDGE;
      case ($urandom_range(2))
        0:       spread = 4;
        1:       spread = 64;
        default: spread = 2048;
      endcase
      for (i = 0; i < n_vert; i++) begin
        x = pick_coord(style, qry_x, spread);
        y = pick_coord(style, qry_y, spread);
        first = (i == 0) ? ($urandom_range(99) < 92) : ($urandom_range(99) < 3);
        last  = (i == n_vert - 1) && ($urandom_range(99) < 95);
        send_vertex(x, y, first, last);
        sent++;
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    nearest_rec_t want;
    if (rst_n && res.valid && res.ready) begin
      if (nearest_due.size() == 0) begin
        $display("%0t: unexpected result word dist=%0d x=%0d y=%0d no_segment=%0b", $time,
                 res.min_dist_sq, res.nearest_x, res.nearest_y, res.no_segment);
        errors++;
      end else begin
        want = nearest_due.pop_front();
        if (res.min_dist_sq !== want.dsq) begin
          $display("%0t: min_dist_sq expected %0d actual %0d", $time, want.dsq,
                   res.min_dist_sq);
          errors++;
        end
        if (res.nearest_x !== want.nx) begin
          $display("%0t: nearest_x expected %0d actual %0d", $time, want.nx, res.nearest_x);
          errors++;
        end
        if (res.nearest_y !== want.ny) begin
          $display("%0t: nearest_y expected %0d actual %0d", $time, want.ny, res.nearest_y);
          errors++;
        end
        if (res.no_segment !== want.empty) begin
          $display("%0t: no_segment expected %0b actual %0b", $time, want.empty,
                   res.no_segment);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (!rst_n || (vert.valid && vert.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("point_polyline_min_distance test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_QUERY_X;
    cfg_wdata         = '0;
    vert.valid        = 1'b0;
    vert.vertex_x     = '0;
    vert.vertex_y     = '0;
    vert.first_vertex = 1'b0;
    vert.last_vertex  = 1'b0;
    qry_x             = '0;
    qry_y             = '0;
    held_x            = '0;
    held_y            = '0;
    restart_polyline();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_lone_vertex();
    test_extreme_coords();
    test_projection_cases();
    test_restart_flags();
    test_query_change();
    run_random(500, 28, 80);
    run_random(500, 80, 28);
    run_random(500, 0, 0);
    drain_block();

    if (errors == 0) begin
      $display("point_polyline_min_distance test passed");
    end else begin
      $display("point_polyline_min_distance test failed");
    end
    $finish;
  end

endmodule
